### sv/wrv_pkg.sv
// shared widths, register indexes and reset values for the windowed range validator
package wrv_pkg;

    localparam int LEN_REG_W = 6;
    localparam int REG_W     = 20;
    localparam int OUT_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT  = 2'd3;

    localparam logic [LEN_REG_W-1:0] RST_WINDOW_LENGTH = 6'd10;
    localparam logic [REG_W-1:0]     RST_RANGE_LOW     = 20'd1600;
    localparam logic [REG_W-1:0]     RST_RANGE_HIGH    = 20'd9600;
    localparam logic [REG_W-1:0]     RST_SPREAD_LIMIT  = 20'd160;

endpackage

### sv/windowed_range_validator.sv
// windowed range validator: block average of distance samples with spread and range check
//
// Samples are summed, with running minimum and maximum, over non-overlapping windows of
// window_length samples (zero counts as one, values above MAX_WINDOW count as MAX_WINDOW).
// A sample that does not close a window leaves the block idle, so such samples may arrive
// back to back. A sample that closes a window drops in_ready until the block is idle again:
// the mean comes from a restoring divider that retires one quotient bit per cycle over SUM_W
// = SAMPLE_BITS + clog2(MAX_WINDOW+1) bits, followed by a state for the deviation and range
// compare (S_DEV) and one for the spread compare (S_EMIT). If an
// accepted mean finds the previous result still unread in the output register, the block
// holds in that last step until it is taken. An accepted mean is emitted only when the
// largest deviation from it is within spread_limit and it lies in [range_low, range_high];
// the window restarts either way. Register writes take effect at once and do not clear the
// window.
module windowed_range_validator #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [SAMPLE_BITS-1:0]          sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wrv_pkg::OUT_W-1:0]       mean_distance,
    input  logic                            cfg_we,
    input  logic [wrv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrv_pkg::REG_W-1:0]       cfg_data
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int CMP_W  = (SUM_W > wrv_pkg::REG_W) ? SUM_W : wrv_pkg::REG_W;
    localparam int LEN_W  = (CNT_W > wrv_pkg::LEN_REG_W) ? CNT_W : wrv_pkg::LEN_REG_W;
    localparam int ITER_W = $clog2(SUM_W + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DEV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [wrv_pkg::LEN_REG_W-1:0] window_length_reg;
    logic [wrv_pkg::REG_W-1:0]     range_low_reg;
    logic [wrv_pkg::REG_W-1:0]     range_high_reg;
    logic [wrv_pkg::REG_W-1:0]     spread_limit_reg;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SUM_W-1:0]       dq_reg, dq_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       div_reg, div_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic [CMP_W-1:0]       dev_reg, dev_next;
    logic                   range_ok_reg, range_ok_next;
    logic                   out_valid_reg, out_valid_next;
    logic [wrv_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic [LEN_W-1:0]       wl_ext, n_ext;
    logic [CNT_W-1:0]       n_eff;
    logic                   in_fire;
    logic [SUM_W-1:0]       sum_acc;
    logic [SAMPLE_BITS-1:0] min_acc, max_acc;
    logic [CNT_W-1:0]       fill_acc;
    logic [CNT_W:0]         trial, diff;
    logic                   ge;
    logic [CMP_W-1:0]       mean_c, max_c, min_c, dev_hi, dev_lo;
    logic                   ok, out_free;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign mean_distance = out_data_reg;

    // effective window length
    always_comb
    begin
        wl_ext = LEN_W'(window_length_reg);
        if (wl_ext == '0)
        begin
            n_ext = LEN_W'(1);
        end
        else if (wl_ext > LEN_W'(MAX_WINDOW))
        begin
            n_ext = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            n_ext = wl_ext;
        end
        n_eff = n_ext[CNT_W-1:0];
    end

    always_comb
    begin
        sum_acc  = sum_reg + SUM_W'(sample);
        min_acc  = (sample < min_reg) ? sample : min_reg;
        max_acc  = (sample > max_reg) ? sample : max_reg;
        fill_acc = fill_reg + CNT_W'(1);

        trial = {rem_reg, dq_reg[SUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});

        mean_c = CMP_W'(dq_reg);
        max_c  = CMP_W'(max_reg);
        min_c  = CMP_W'(min_reg);
        dev_hi = (max_c > mean_c) ? (max_c - mean_c) : '0;
        dev_lo = (mean_c > min_c) ? (mean_c - min_c) : '0;

        ok       = range_ok_reg && (dev_reg <= CMP_W'(spread_limit_reg));
        out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        iter_next      = iter_reg;
        dev_next       = dev_reg;
        range_ok_next  = range_ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sum_next  = sum_acc;
                    min_next  = min_acc;
                    max_next  = max_acc;
                    fill_next = fill_acc;
                    if (fill_acc >= n_eff)
                    begin
                        dq_next    = sum_acc;
                        rem_next   = '0;
                        div_next   = n_eff;
                        iter_next  = ITER_W'(SUM_W);
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                dq_next   = {dq_reg[SUM_W-2:0], ge};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = S_DEV;
                end
            end
            S_DEV:
            begin
                dev_next      = (dev_hi > dev_lo) ? dev_hi : dev_lo;
                range_ok_next = (mean_c >= CMP_W'(range_low_reg)) &&
                                (mean_c <= CMP_W'(range_high_reg));
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ok || out_free)
                begin
                    if (ok)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = wrv_pkg::OUT_W'(dq_reg);
                    end
                    fill_next  = '0;
                    sum_next   = '0;
                    min_next   = '1;
                    max_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= wrv_pkg::RST_WINDOW_LENGTH;
            range_low_reg     <= wrv_pkg::RST_RANGE_LOW;
            range_high_reg    <= wrv_pkg::RST_RANGE_HIGH;
            spread_limit_reg  <= wrv_pkg::RST_SPREAD_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wrv_pkg::CFG_WINDOW_LENGTH:
                begin
                    window_length_reg <= cfg_data[wrv_pkg::LEN_REG_W-1:0];
                end
                wrv_pkg::CFG_RANGE_LOW:
                begin
                    range_low_reg <= cfg_data;
                end
                wrv_pkg::CFG_RANGE_HIGH:
                begin
                    range_high_reg <= cfg_data;
                end
                wrv_pkg::CFG_SPREAD_LIMIT:
                begin
                    spread_limit_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            sum_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        dev_reg      <= dev_next;
        range_ok_reg <= range_ok_next;
        out_data_reg <= out_data_next;
    end

endmodule

### sv/wrv_checker.sv
// port-level assertions for the windowed range validator and their bind
module wrv_checker #(
    parameter int SAMPLE_BITS = 20
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [SAMPLE_BITS-1:0]          sample,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [wrv_pkg::OUT_W-1:0]       mean_distance,
    input logic                            cfg_we,
    input logic [wrv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [wrv_pkg::REG_W-1:0]       cfg_data
);

    logic unused_ok;
    assign unused_ok = ^{sample, cfg_we, cfg_index, cfg_data};

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_distance))
        else $error("result dropped or changed while stalled");

    // a new result appears only while the block is busy with a closing request
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a closing request");

    // the block goes busy only after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("input stalled without an accepted request");

    // an idle block does not refill the output after it is read
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && in_ready |=> !out_valid)
        else $error("result repeated or invented");

endmodule

bind windowed_range_validator wrv_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wrv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mean_distance (mean_distance),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

### test/tb.sv
// self-checking testbench for the windowed range validator: random and directed sample requests
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_W     = 20;
    localparam int MAX_LEN      = 32;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [SAMPLE_W-1:0]           sample = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [wrv_pkg::OUT_W-1:0]     mean_distance;
    logic                          cfg_we = 1'b0;
    logic [wrv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wrv_pkg::REG_W-1:0]     cfg_data = '0;

    logic [SAMPLE_W-1:0]           sample_q[$];
    logic [wrv_pkg::OUT_W-1:0]     expected_means[$];

    logic [wrv_pkg::LEN_REG_W-1:0] cfg_len = wrv_pkg::RST_WINDOW_LENGTH;
    logic [wrv_pkg::REG_W-1:0]     cfg_lo = wrv_pkg::RST_RANGE_LOW;
    logic [wrv_pkg::REG_W-1:0]     cfg_hi = wrv_pkg::RST_RANGE_HIGH;
    logic [wrv_pkg::REG_W-1:0]     cfg_spread = wrv_pkg::RST_SPREAD_LIMIT;

    int unsigned          win_fill = 0;
    logic [24:0]          win_sum = '0;
    logic [SAMPLE_W-1:0]  win_min = '1;
    logic [SAMPLE_W-1:0]  win_max = '0;

    int                   errors = 0;
    int                   cycle_count = 0;
    int                   in_idle_pct = 35;
    int                   out_idle_pct = 35;

    windowed_range_validator #(
        .MAX_WINDOW (MAX_LEN),
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_distance(mean_distance),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned effective_len(input logic [wrv_pkg::LEN_REG_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_LEN)
            return MAX_LEN;
        return len;
    endfunction

    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
        logic [24:0] n;
        logic [24:0] mean;
        logic [24:0] dev_hi;
        logic [24:0] dev_lo;
        logic [24:0] dev;
        win_sum = win_sum + s;
        if (s < win_min)
            win_min = s;
        if (s > win_max)
            win_max = s;
        win_fill++;
        n = 25'(effective_len(cfg_len));
        if (win_fill >= n)
        begin
            mean = win_sum / n;
            dev_hi = (win_max > mean) ? win_max - mean : '0;
            dev_lo = (mean > win_min) ? mean - win_min : '0;
            dev = (dev_hi > dev_lo) ? dev_hi : dev_lo;
            if (dev <= cfg_spread && mean >= cfg_lo && mean <= cfg_hi)
                expected_means.push_back(mean[wrv_pkg::OUT_W-1:0]);
            win_fill = 0;
            win_sum = '0;
            win_min = '1;
            win_max = '0;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                accumulate_sample(sample);
            if (!in_valid || in_ready)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    in_valid <= 1'b1;
                    sample <= sample_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        logic [wrv_pkg::OUT_W-1:0] want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected mean_distance, expected none, actual %0d",
                             $time, mean_distance);
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (mean_distance !== want)
                    begin
                        errors++;
                        $display("%0t: mean_distance mismatch, expected %0d, actual %0d",
                                 $time, want, mean_distance);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_one(input logic [wrv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wrv_pkg::REG_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [wrv_pkg::LEN_REG_W-1:0] len,
                            input logic [wrv_pkg::REG_W-1:0] lo,
                            input logic [wrv_pkg::REG_W-1:0] hi,
                            input logic [wrv_pkg::REG_W-1:0] spread);
        logic [wrv_pkg::REG_W-1:0] len_word;
        len_word = {14'($urandom), len};
        write_one(wrv_pkg::CFG_WINDOW_LENGTH, len_word);
        write_one(wrv_pkg::CFG_RANGE_LOW, lo);
        write_one(wrv_pkg::CFG_RANGE_HIGH, hi);
        write_one(wrv_pkg::CFG_SPREAD_LIMIT, spread);
        cfg_we <= 1'b0;
        cfg_len = len_word[wrv_pkg::LEN_REG_W-1:0];
        cfg_lo = lo;
        cfg_hi = hi;
        cfg_spread = spread;
    endtask

    // hold off until every expected mean has arrived and the block has settled
    task automatic drain();
        while (sample_q.size() != 0 || in_valid || expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned                   phase;
        int unsigned                   random_pushed;
        int unsigned                   windows;
        int unsigned                   eff;
        int unsigned                   r;
        int unsigned                   center;
        int unsigned                   span;
        int unsigned                   a;
        int unsigned                   b;
        longint                        v;
        logic [wrv_pkg::LEN_REG_W-1:0] len;
        logic [wrv_pkg::REG_W-1:0]     lo;
        logic [wrv_pkg::REG_W-1:0]     hi;
        logic [wrv_pkg::REG_W-1:0]     spread;

        phase = 0;
        random_pushed = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one clean ten-sample window
        for (int i = 0; i < 10; i++)
            sample_q.push_back(SAMPLE_W'(4000 + 10 * i));
        drain();

        // single-sample windows at the field extremes
        set_regs(6'd1, '0, '1, '0);
        sample_q.push_back('0);
        sample_q.push_back('1);
        sample_q.push_back(20'h55555);
        sample_q.push_back(20'hAAAAA);
        drain();

        // zero length acts as one, mean on both range bounds and just outside
        set_regs(6'd0, 20'd1000, 20'd1000, '1);
        sample_q.push_back(20'd1000);
        sample_q.push_back(20'd999);
        sample_q.push_back(20'd1001);
        drain();

        // deviation exactly at the spread limit, then one past it
        set_regs(6'd2, '0, '1, 20'd5);
        sample_q.push_back(20'd100);
        sample_q.push_back(20'd110);
        sample_q.push_back(20'd100);
        sample_q.push_back(20'd111);
        drain();

        // empty range
        set_regs(6'd1, 20'd10, 20'd9, '1);
        sample_q.push_back(20'd9);
        sample_q.push_back(20'd10);
        drain();

        // length lowered in the middle of a window
        set_regs(6'd8, '0, '1, '1);
        sample_q.push_back(20'd100);
        sample_q.push_back(20'd200);
        sample_q.push_back(20'd300);
        drain();
        set_regs(6'd2, '0, '1, '1);
        sample_q.push_back(20'd400);
        drain();

        while (random_pushed < RANDOM_ITEMS)
        begin
            phase++;
            in_idle_pct = (phase == 3) ? 0 : 35;
            out_idle_pct = in_idle_pct;

            r = $urandom_range(99);
            if (phase == 1 || r < 8)
                len = 6'd32;
            else if (r < 16)
                len = 6'd0;
            else if (r < 22)
                len = 6'($urandom_range(63, 33));
            else if (r < 28)
                len = 6'd1;
            else
                len = 6'($urandom_range(12, 2));

            r = $urandom_range(99);
            if (phase == 1 || r < 25)
            begin
                lo = '0;
                hi = '1;
            end
            else if (r < 35)
            begin
                a = $urandom_range(1048575, 1);
                lo = wrv_pkg::REG_W'(a);
                hi = wrv_pkg::REG_W'($urandom_range(a - 1, 0));
            end
            else if (r < 65)
            begin
                a = $urandom_range(1048575);
                b = a + $urandom_range(5000);
                lo = wrv_pkg::REG_W'(a);
                hi = (b > 1048575) ? '1 : wrv_pkg::REG_W'(b);
            end
            else
            begin
                a = $urandom_range(1048575);
                b = $urandom_range(1048575);
                lo = wrv_pkg::REG_W'((a < b) ? a : b);
                hi = wrv_pkg::REG_W'((a < b) ? b : a);
            end

            r = $urandom_range(99);
            if (phase == 1 || r < 15)
                spread = '1;
            else if (r < 30)
                spread = '0;
            else
                spread = wrv_pkg::REG_W'($urandom_range(2000));

            set_regs(len, lo, hi, spread);
            eff = effective_len(len);
            windows = (phase == 3) ? 40 : $urandom_range(10, 4);

            for (int w = 0; w < windows; w++)
            begin
                r = $urandom_range(99);
                if (r < 5)
                begin
                    // noise run of one to eff samples, which can shift the window alignment
                    a = $urandom_range(eff, 1);
                    for (int k = 0; k < a; k++)
                        sample_q.push_back(SAMPLE_W'($urandom));
                    random_pushed += a;
                end
                else if (r < 20)
                begin
                    for (int k = 0; k < eff; k++)
                        sample_q.push_back(SAMPLE_W'($urandom));
                    random_pushed += eff;
                end
                else
                begin
                    // clustered window around a center inside the range, or anywhere if the range is empty
                    if (lo <= hi)
                        center = $urandom_range(hi, lo);
                    else
                        center = $urandom_range(1048575);
                    if ($urandom_range(2) == 0)
                        span = 0;
                    else
                    begin
                        span = spread + spread / 8 + 1;
                        if (span > 200000)
                            span = 200000;
                        span = $urandom_range(span);
                    end
                    for (int k = 0; k < eff; k++)
                    begin
                        v = longint'(center) + longint'($urandom_range(2 * span))
                            - longint'(span);
                        if (v < 0)
                            v = 0;
                        if (v > 1048575)
                            v = 1048575;
                        sample_q.push_back(SAMPLE_W'(v));
                    end
                    random_pushed += eff;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
